// ===== rtl/core/sue_pkg.sv =====
// Shared types, constants and helper functions of the string unescaper.
package sue_pkg;

    localparam int unsigned WinDepth = 12;

    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic       RST_ESCAPE_ENABLE = 1'b1;
    localparam logic [7:0] RST_ESCAPE_BYTE   = 8'd92;
    localparam logic [7:0] RST_QUOTE_BYTE    = 8'd34;
    localparam logic       RST_DQ_ENABLE     = 1'b1;

    // Top six bits of a high and of a low surrogate.
    localparam logic [5:0] HI_SURR_TOP = 6'b110110;
    localparam logic [5:0] LO_SURR_TOP = 6'b110111;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [1:0] {
        CFG_ESCAPE_ENABLE = 2'd0,
        CFG_ESCAPE_BYTE   = 2'd1,
        CFG_QUOTE_BYTE    = 2'd2,
        CFG_DQ_ENABLE     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       escape_enable;
        logic [7:0] escape_byte;
        logic [7:0] quote_byte;
        logic       double_quote_enable;
    } t_cfg;

    // One raw byte with its configuration-independent classification.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_u;
        logic       esc_ok;
        logic [7:0] esc_val;
    } t_sym;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            CH_APOS:   r = {1'b1, CH_APOS};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_T:      r = {1'b1, CH_TAB};
            CH_B:      r = {1'b1, CH_BS};
            CH_R:      r = {1'b1, CH_CR};
            CH_N:      r = {1'b1, CH_LF};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r.len   = 3'd1;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sue_front.sv =====
// Input side: classifies each raw byte and holds it in a two-entry queue.
module sue_front
    import sue_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_q_valid,
    output t_sym       o_q_sym,
    input  logic       i_q_pop
);

    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    t_sym               r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QCntW-1:0]   r_cnt;
    logic               push;
    logic               pop;
    t_sym               sym;
    logic [4:0]         hex;
    logic [8:0]         esc;

    assign o_ready   = (r_cnt != QCntW'(QDepth));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_sym   = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        hex         = hex_decode(i_data);
        esc         = esc_decode(i_data);
        sym.data    = i_data;
        sym.last    = i_last;
        sym.hex_ok  = hex[4];
        sym.hex_val = hex[3:0];
        sym.is_u    = (i_data == CH_U);
        sym.esc_ok  = esc[8];
        sym.esc_val = esc[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + QCntW'(push) - QCntW'(pop);
        end
    end

endmodule

// ===== rtl/core/sue_back.sv =====
// Decode side: lookahead window, escape decision, UTF-8 encoding and output register.
module sue_back
    import sue_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_sym       i_q_sym,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last
);

    typedef enum logic [2:0] {
        S_FILL   = 3'b001,
        S_DECIDE = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_sym            r_buf [WinDepth];
    logic [3:0]      r_count;
    logic            r_fin;
    logic [2:0][7:0] r_rest;
    logic [1:0]      r_rem;
    logic            r_rest_last;
    logic            r_out_valid;
    logic [7:0]      r_out_data;
    logic            r_out_last;

    logic            out_free;
    logic            append;
    logic            take;
    logic            emit_rest;
    logic [2:0]      d_cnt;
    logic [3:0]      d_used;
    logic [3:0][7:0] d_bytes;
    logic            d_last_call;
    logic [15:0]     hi;
    logic [15:0]     lo;
    logic            hi_ok;
    logic            lo_ok;
    logic [20:0]     cp_pair;
    t_utf8           enc_hi;
    t_utf8           enc_pair;
    logic            esc0;
    logic [3:0]      n_count_dec;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

    assign append    = (r_state == S_FILL) && i_q_valid;
    assign o_q_pop   = append;
    assign take      = (r_state == S_DECIDE) && out_free && (d_cnt != 3'd0);
    assign emit_rest = (r_state == S_EMIT) && out_free;

    // Decision on the head of the window; a zero count means more bytes are needed.
    always_comb begin
        hi    = {r_buf[2].hex_val, r_buf[3].hex_val, r_buf[4].hex_val, r_buf[5].hex_val};
        lo    = {r_buf[8].hex_val, r_buf[9].hex_val, r_buf[10].hex_val, r_buf[11].hex_val};
        hi_ok = r_buf[2].hex_ok && r_buf[3].hex_ok && r_buf[4].hex_ok && r_buf[5].hex_ok;
        lo_ok = r_buf[8].hex_ok && r_buf[9].hex_ok && r_buf[10].hex_ok && r_buf[11].hex_ok;
        cp_pair  = 21'({hi[9:0], lo[9:0]}) + SUPP_BASE;
        enc_hi   = utf8_encode({5'd0, hi});
        enc_pair = utf8_encode(cp_pair);
        esc0     = i_cfg.escape_enable && (r_buf[0].data == i_cfg.escape_byte);

        d_cnt      = 3'd1;
        d_used     = 4'd1;
        d_bytes    = '0;
        d_bytes[0] = r_buf[0].data;

        if (esc0) begin
            if (r_count < 4'd2) begin
                d_cnt = r_fin ? 3'd1 : 3'd0;
            end else if (r_buf[1].esc_ok) begin
                d_bytes[0] = r_buf[1].esc_val;
                d_used     = 4'd2;
            end else if (r_buf[1].is_u) begin
                if (r_count < 4'd6) begin
                    d_cnt = r_fin ? 3'd1 : 3'd0;
                end else if (hi_ok) begin
                    if (hi[15:10] == HI_SURR_TOP) begin
                        if (r_count < 4'd12) begin
                            d_cnt = r_fin ? 3'd1 : 3'd0;
                        end else if (r_buf[6].data == i_cfg.escape_byte && r_buf[7].is_u
                                     && lo_ok && lo[15:10] == LO_SURR_TOP) begin
                            d_cnt   = enc_pair.len;
                            d_bytes = enc_pair.bytes;
                            d_used  = 4'd12;
                        end
                    end else begin
                        d_cnt   = enc_hi.len;
                        d_bytes = enc_hi.bytes;
                        d_used  = 4'd6;
                    end
                end
            end
        end else if (i_cfg.double_quote_enable && r_buf[0].data == i_cfg.quote_byte) begin
            if (r_count < 4'd2) begin
                d_cnt = r_fin ? 3'd1 : 3'd0;
            end else if (r_buf[1].data == i_cfg.quote_byte) begin
                d_used = 4'd2;
            end
        end

        n_count_dec = r_count - d_used;
        d_last_call = r_fin && (r_count == d_used);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                if (append) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (d_cnt == 3'd0) begin
                    n_state = S_FILL;
                end else if (take) begin
                    if (d_cnt > 3'd1) begin
                        n_state = S_EMIT;
                    end else if (n_count_dec != 4'd0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_EMIT: begin
                if (emit_rest && r_rem == 2'd1) begin
                    n_state = (r_count != 4'd0) ? S_DECIDE : S_FILL;
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    // Window entries: append at the fill position, or drop the decided bytes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WinDepth; i++) begin
            if (take) begin
                if (d_used == 4'd1) begin
                    r_buf[i] <= r_buf[(i + 1) % WinDepth];
                end else if (d_used == 4'd2) begin
                    r_buf[i] <= r_buf[(i + 2) % WinDepth];
                end else if (d_used == 4'd6) begin
                    r_buf[i] <= r_buf[(i + 6) % WinDepth];
                end
            end else if (append && r_count == 4'(i)) begin
                r_buf[i] <= i_q_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rest      <= d_bytes[3:1];
            r_rest_last <= d_last_call;
        end else if (emit_rest) begin
            r_rest <= {8'h00, r_rest[2:1]};
        end
        if (take) begin
            r_out_data <= d_bytes[0];
            r_out_last <= d_last_call && (d_cnt == 3'd1);
        end else if (emit_rest) begin
            r_out_data <= r_rest[0];
            r_out_last <= r_rest_last && (r_rem == 2'd1);
        end
        if (append) begin
            r_fin <= i_q_sym.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_count <= n_count_dec;
                r_rem   <= 2'(d_cnt - 3'd1);
            end else begin
                if (append && r_count < 4'(WinDepth)) begin
                    r_count <= r_count + 4'd1;
                end
                if (emit_rest) begin
                    r_rem <= r_rem - 2'd1;
                end
            end
            r_out_valid <= take || emit_rest || (r_out_valid && !i_ready);
        end
    end

endmodule

// ===== rtl/core/string_unescaper_utf8_unit.sv =====
// Top level of the streaming string unescaper with UTF-8 output.
//
//   channel   dir  fields (lowest bit first)       handshake
//   s_axis    in   tdata: in_byte; tlast: in_last  tvalid & tready
//   m_axis    out  tdata: out_byte; tlast: out_last tvalid & tready
//   cfg       in   idx: register, data: value      i_cfg_we
//
// A plain byte is moved from the input queue into the 12-byte lookahead window
// and then decided and loaded into the output register. A decision that yields
// several bytes holds the decode unit until all are sent, and at the end of a
// string each buffered byte is decided one per cycle while the output accepts.
// Reset clears the window and the input queue and loads the register defaults.
// The input queue fills up while the decode side waits on the output.
module string_unescaper_utf8_unit
    import sue_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_valid;
    t_sym q_sym;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_enable       <= RST_ESCAPE_ENABLE;
            r_cfg.escape_byte         <= RST_ESCAPE_BYTE;
            r_cfg.quote_byte          <= RST_QUOTE_BYTE;
            r_cfg.double_quote_enable <= RST_DQ_ENABLE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ESCAPE_ENABLE: r_cfg.escape_enable       <= i_cfg_data[0];
                CFG_ESCAPE_BYTE:   r_cfg.escape_byte         <= i_cfg_data;
                CFG_QUOTE_BYTE:    r_cfg.quote_byte          <= i_cfg_data;
                CFG_DQ_ENABLE:     r_cfg.double_quote_enable <= i_cfg_data[0];
                default:           r_cfg                     <= r_cfg;
            endcase
        end
    end

    sue_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_q_valid (q_valid),
        .o_q_sym   (q_sym),
        .i_q_pop   (q_pop)
    );

    sue_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_sym   (q_sym),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== tb/string_unescaper_utf8_unit_checker.sv =====
// Checker that predicts and compares the unescaped byte stream of the string unescaper.
`timescale 1ns / 1ps

module string_unescaper_utf8_unit_checker
    import sue_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_unesc_byte;

    t_cfg        cfg;
    logic [7:0]  held_bytes [WinDepth];
    int unsigned held_count = 0;
    t_unesc_byte expected_bytes [$];
    int unsigned fail_count = 0;

    initial begin
        o_fail_count = '0;
        o_pending    = '0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic int unsigned hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return 10 + c - "a";
        if (c >= "A" && c <= "F") return 10 + c - "A";
        return 16;
    endfunction

    function automatic logic hex_word(input int unsigned pos, output int unsigned val);
        int unsigned d;
        val = 0;
        for (int i = 0; i < 4; i++) begin
            d = hex_nibble(held_bytes[pos + i]);
            if (d > 15) return 1'b0;
            val = (val << 4) | d;
        end
        return 1'b1;
    endfunction

    // UTF-8 bytes of a code point, first byte in the low bits of enc.
    function automatic int unsigned utf8_pack(input int unsigned cp, output logic [31:0] enc);
        enc = '0;
        if (cp < 'h80) begin
            enc[7:0] = cp[7:0];
            return 1;
        end
        if (cp <= 'h7FF) begin
            enc[7:0]  = 8'hC0 | cp[10:6];
            enc[15:8] = 8'h80 | cp[5:0];
            return 2;
        end
        if (cp <= 'hFFFF) begin
            enc[7:0]   = 8'hE0 | cp[15:12];
            enc[15:8]  = 8'h80 | cp[11:6];
            enc[23:16] = 8'h80 | cp[5:0];
            return 3;
        end
        enc[7:0]   = 8'hF0 | cp[20:18];
        enc[15:8]  = 8'h80 | cp[17:12];
        enc[23:16] = 8'h80 | cp[11:6];
        enc[31:24] = 8'h80 | cp[5:0];
        return 4;
    endfunction

    // Settles the byte at the head of the window. Returns the number of output
    // bytes (zero while more input is needed) and how many bytes it consumes.
    function automatic int unsigned decide_front(input logic fin, output logic [31:0] enc,
                                                 output int unsigned used);
        int unsigned n;
        int unsigned hi;
        int unsigned lo;
        logic [7:0]  e;
        logic        simple;
        n    = held_count;
        used = 1;
        enc  = {24'd0, held_bytes[0]};
        if (cfg.escape_enable && held_bytes[0] == cfg.escape_byte) begin
            if (n < 2) return fin ? 1 : 0;
            e      = held_bytes[1];
            simple = 1'b1;
            case (e) inside
                CH_APOS, CH_DQUOTE, CH_BSLASH, CH_SLASH: enc[7:0] = e;
                CH_T:    enc[7:0] = CH_TAB;
                CH_B:    enc[7:0] = CH_BS;
                CH_R:    enc[7:0] = CH_CR;
                CH_N:    enc[7:0] = CH_LF;
                default: simple = 1'b0;
            endcase
            if (simple) begin
                used = 2;
                return 1;
            end
            if (e != CH_U) return 1;
            if (n < 6) return fin ? 1 : 0;
            if (!hex_word(2, hi)) return 1;
            if (hi >= 'hD800 && hi <= 'hDBFF) begin
                // A high surrogate needs the whole second escape before it is settled.
                if (n < 12) return fin ? 1 : 0;
                if (held_bytes[6] != cfg.escape_byte || held_bytes[7] != CH_U) return 1;
                if (!hex_word(8, lo)) return 1;
                if (lo < 'hDC00 || lo > 'hDFFF) return 1;
                used = 12;
                return utf8_pack(((hi - 'hD800) << 10) + (lo - 'hDC00) + 'h10000, enc);
            end
            used = 6;
            return utf8_pack(hi, enc);
        end
        if (cfg.double_quote_enable && held_bytes[0] == cfg.quote_byte) begin
            if (n < 2) return fin ? 1 : 0;
            if (held_bytes[1] == cfg.quote_byte) used = 2;
            return 1;
        end
        return 1;
    endfunction

    function automatic void unescape_step(input logic [7:0] in_byte, input logic fin);
        t_unesc_byte batch [$];
        t_unesc_byte item;
        logic [31:0] enc;
        int unsigned used;
        int unsigned cnt;
        if (held_count < WinDepth) begin
            held_bytes[held_count] = in_byte;
            held_count++;
        end
        while (held_count > 0) begin
            cnt = decide_front(fin, enc, used);
            if (cnt == 0) break;
            if (used > held_count) used = held_count;
            for (int k = 0; k < cnt && batch.size() < WinDepth; k++) begin
                item.data = enc[8*k +: 8];
                item.last = 1'b0;
                batch.push_back(item);
            end
            for (int i = 0; i + used < held_count; i++) begin
                held_bytes[i] = held_bytes[i + used];
            end
            held_count -= used;
        end
        if (fin) begin
            held_count = 0;
            if (batch.size() > 0) begin
                item      = batch[batch.size() - 1];
                item.last = 1'b1;
                batch[batch.size() - 1] = item;
            end
        end
        foreach (batch[i]) expected_bytes.push_back(batch[i]);
    endfunction

    always @(posedge i_clk) begin : watch
        t_unesc_byte want;
        if (!i_rst_n) begin
            cfg.escape_enable       = RST_ESCAPE_ENABLE;
            cfg.escape_byte         = RST_ESCAPE_BYTE;
            cfg.quote_byte          = RST_QUOTE_BYTE;
            cfg.double_quote_enable = RST_DQ_ENABLE;
            held_count = 0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ESCAPE_ENABLE: cfg.escape_enable       = i_cfg_data[0];
                    CFG_ESCAPE_BYTE:   cfg.escape_byte         = i_cfg_data;
                    CFG_QUOTE_BYTE:    cfg.quote_byte          = i_cfg_data;
                    CFG_DQ_ENABLE:     cfg.double_quote_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                unescape_step(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("out_byte %02h arrived with none expected",
                                              i_m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_m_tdata !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_m_tdata, want.data));
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch($sformatf("out_last %0b on byte %02h, expected %0b",
                                                  i_m_tlast, i_m_tdata, want.last));
                    end
                end
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/string_unescaper_utf8_unit_tb.sv =====
// Testbench top of the string unescaper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module string_unescaper_utf8_unit_tb
    import sue_pkg::*;
();

    localparam int unsigned PhaseBytes = 42;
    localparam int unsigned SettleCycles = 48;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [7:0]  cfg_data = '0;
    logic [31:0] fail_count;
    logic [31:0] pending;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic [7:0]  gen_esc = RST_ESCAPE_BYTE;
    logic [7:0]  gen_quote = RST_QUOTE_BYTE;
    logic [7:0]  str_buf [$];

    string_unescaper_utf8_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    string_unescaper_utf8_unit_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [7:0] data, input logic last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_buf.size(); i++) begin
            send_item(str_buf[i], i == str_buf.size() - 1);
        end
    endtask

    // Waits for every expected byte, then lets the block finish any work that
    // yields no output before the next register write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic program_regs(input logic esc_en, input logic [7:0] esc, input logic [7:0] quote,
                                input logic dq_en);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ESCAPE_ENABLE;
        cfg_data <= {7'd0, esc_en};
        @(posedge clk);
        cfg_idx  <= CFG_ESCAPE_BYTE;
        cfg_data <= esc;
        @(posedge clk);
        cfg_idx  <= CFG_QUOTE_BYTE;
        cfg_data <= quote;
        @(posedge clk);
        cfg_idx  <= CFG_DQ_ENABLE;
        cfg_data <= {7'd0, dq_en};
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_esc   = esc;
        gen_quote = quote;
    endtask

    task automatic program_phase(input int unsigned p);
        case (p)
            0: program_regs(1'b1, RST_ESCAPE_BYTE, RST_QUOTE_BYTE, 1'b1);
            1: program_regs(1'b1, CH_DQUOTE, CH_DQUOTE, 1'b1);
            2: program_regs(1'b0, RST_ESCAPE_BYTE, RST_QUOTE_BYTE, 1'b1);
            3: program_regs(1'b1, 8'hFF, 8'h00, 1'b0);
            4: program_regs(1'b1, 8'h00, 8'hFF, 1'b1);
            5: program_regs(1'b0, 8'h00, 8'h00, 1'b0);
            6: program_regs(1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? 8'($urandom) : RST_ESCAPE_BYTE,
                            8'($urandom), 1'($urandom_range(0, 1)));
            default: program_regs(1'b1, RST_ESCAPE_BYTE, RST_QUOTE_BYTE, 1'b1);
        endcase
    endtask

    task automatic set_idling(input int unsigned p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
            default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
        endcase
    endtask

    function automatic void push_text(input string t);
        for (int i = 0; i < t.len(); i++) str_buf.push_back(t[i]);
    endfunction

    // Escape, u and four hex digits of cp, letters in random case.
    function automatic void push_u_hex(input int unsigned cp);
        int unsigned nib;
        str_buf.push_back(gen_esc);
        str_buf.push_back(CH_U);
        for (int i = 3; i >= 0; i--) begin
            nib = (cp >> (4 * i)) & 'hF;
            if (nib < 10) str_buf.push_back(8'("0" + nib));
            else if ($urandom_range(0, 1) != 0) str_buf.push_back(8'("A" + nib - 10));
            else str_buf.push_back(8'("a" + nib - 10));
        end
    endfunction

    // Mostly well-formed escapes with random content, some noise and broken ones.
    function automatic void build_string();
        int unsigned ntok;
        int unsigned cp;
        int unsigned keep;
        str_buf.delete();
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
            case ($urandom_range(0, 15))
                0: str_buf.push_back(8'($urandom_range(0, 255)));
                1, 2, 14, 15: str_buf.push_back(8'($urandom_range(32, 126)));
                3: begin
                    str_buf.push_back(gen_esc);
                    case ($urandom_range(0, 7))
                        0: str_buf.push_back(CH_APOS);
                        1: str_buf.push_back(CH_DQUOTE);
                        2: str_buf.push_back(CH_BSLASH);
                        3: str_buf.push_back(CH_SLASH);
                        4: str_buf.push_back(CH_T);
                        5: str_buf.push_back(CH_B);
                        6: str_buf.push_back(CH_R);
                        default: str_buf.push_back(CH_N);
                    endcase
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: cp = $urandom_range(0, 'h7F);
                        1: cp = $urandom_range('h80, 'h7FF);
                        2: cp = $urandom_range('h800, 'hFFFF);
                        default: cp = ($urandom_range(0, 1) != 0) ? 'hFFFF : 0;
                    endcase
                    push_u_hex(cp);
                end
                5, 6: begin
                    push_u_hex($urandom_range('hD800, 'hDBFF));
                    push_u_hex($urandom_range('hDC00, 'hDFFF));
                end
                7: begin
                    // High surrogate whose partner is missing or malformed.
                    push_u_hex($urandom_range('hD800, 'hDBFF));
                    case ($urandom_range(0, 3))
                        0: str_buf.push_back(8'($urandom_range(32, 126)));
                        1: push_u_hex($urandom_range(0, 'hDBFF));
                        2: begin
                            push_u_hex($urandom_range('hDC00, 'hDFFF));
                            str_buf[str_buf.size() - 1 - $urandom_range(0, 3)] =
                                8'($urandom_range("g", "z"));
                        end
                        default: begin
                            str_buf.push_back(gen_esc);
                            str_buf.push_back(CH_N);
                        end
                    endcase
                end
                8: begin
                    str_buf.push_back(gen_esc);
                    str_buf.push_back(8'($urandom_range(0, 255)));
                end
                9: begin
                    str_buf.push_back(gen_quote);
                    str_buf.push_back(gen_quote);
                end
                10: str_buf.push_back(gen_quote);
                11: begin
                    push_u_hex($urandom_range(0, 'hFFFF));
                    str_buf[str_buf.size() - 1 - $urandom_range(0, 3)] =
                        8'($urandom_range("g", "z"));
                end
                12: push_u_hex($urandom_range('hDC00, 'hDFFF));
                default: str_buf.push_back(gen_esc);
            endcase
        end
        // Cutting the string short leaves escapes unfinished at the end.
        if (str_buf.size() > 1 && $urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, str_buf.size() - 1);
            while (str_buf.size() > keep) str_buf.delete(str_buf.size() - 1);
        end
    endfunction

    initial begin : stimulus
        int unsigned phase_bytes;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: two-byte and four-byte UTF-8, a failed escape, an
        // escape as the final byte, doubled quote and the byte extremes.
        str_buf.delete();
        push_text("\\u00e9\\uD83D\\uDE00\\z\\");
        send_string();
        str_buf.delete();
        str_buf.push_back(8'h00);
        push_text("\"\"");
        str_buf.push_back(8'hFF);
        send_string();

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_idling(p);
            program_phase(p);
            if (p == 7) begin
                // Change the quote byte while a unicode escape waits in the window.
                str_buf.delete();
                str_buf.push_back(gen_esc);
                push_text("u00");
                foreach (str_buf[i]) send_item(str_buf[i], 1'b0);
                wait_idle();
                program_regs(1'b1, RST_ESCAPE_BYTE, "Q", 1'b1);
                str_buf.delete();
                push_text("41QQ");
                send_string();
            end
            phase_bytes = 0;
            while (phase_bytes < PhaseBytes) begin
                build_string();
                phase_bytes += str_buf.size();
                send_string();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
